// File: rtl/lcd_mode_stat_timing_core_assert.svh
// Assertion helpers shared by the LCD timing block.
// Each check is sampled on the rising clock edge and is held off while reset is high.
`ifndef LCD_MODE_STAT_TIMING_CORE_ASSERT_SVH
`define LCD_MODE_STAT_TIMING_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define LCDST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lcd timing check failed");

`define LCDST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcd timing implication failed");

`else

`define LCDST_ASSERT(label, clk, rst, prop)

`define LCDST_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/lcdst_pkg.sv
`default_nettype none

package lcdst_pkg;

   // Frame and line geometry, in CPU machine cycles.
   localparam int unsigned FRAME_CYCLES  = 17556;
   localparam int unsigned LINE_CYCLES   = 114;
   localparam int unsigned OAM_CYCLES    = 20;
   localparam int unsigned XFER_CYCLES   = 43;
   localparam int unsigned VISIBLE_LINES = 144;

   // The frame position is found as floor((cc >> 2) / (FRAME_CYCLES / 4)) by a
   // reciprocal multiply that is exact for every 30-bit dividend.
   localparam int unsigned FRAME_ODD_DIV    = FRAME_CYCLES / 4;
   localparam int unsigned FRAME_RECIP_SH   = 43;
   localparam longint unsigned FRAME_RECIP_L =
      ((64'd1 << FRAME_RECIP_SH) + 64'(FRAME_ODD_DIV) - 64'd1) / 64'(FRAME_ODD_DIV);
   localparam logic [30:0] FRAME_RECIP      = 31'(FRAME_RECIP_L);

   // The line is floor((fc >> 1) / (LINE_CYCLES / 2)), exact for every 14-bit dividend.
   localparam int unsigned LINE_ODD_DIV     = LINE_CYCLES / 2;
   localparam int unsigned LINE_RECIP_SH    = 20;
   localparam int unsigned LINE_RECIP_I     =
      ((1 << LINE_RECIP_SH) + LINE_ODD_DIV - 1) / LINE_ODD_DIV;
   localparam logic [14:0] LINE_RECIP       = 15'(LINE_RECIP_I);

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IRQ_ENABLES  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COMPARE = 2'd1;

   // Bit positions inside irq_enables.
   localparam int unsigned EN_HBLANK = 0;
   localparam int unsigned EN_VBLANK = 1;
   localparam int unsigned EN_OAM    = 2;
   localparam int unsigned EN_LYC    = 3;

   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   // Position of one beat within the frame, as handed to the interrupt stage.
   typedef struct packed {
      logic [7:0] line;
      mode_type   mode;
   } pos_type;

   // One result beat, mode in the lowest bits.
   typedef struct packed {
      logic       frame_swap;
      logic       stat_req;
      logic       vblank_irq;
      logic       coincidence;
      logic [7:0] line;
      mode_type   mode;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/lcdst_frame_pos.sv
`default_nettype none

// Three stages: input register, quotient by the frame length, remainder.
module lcdst_frame_pos
   import lcdst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [31:0] in_cycle_count,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic [14:0]      out_fc
);

   logic        s1_v_ff, s2_v_ff, s3_v_ff;
   logic        s1_ready, s2_ready, s3_ready;
   logic [31:0] cc_s1_ff;
   logic [14:0] cc_lo_s2_ff;
   logic [17:0] q_s2_ff;
   logic [14:0] fc_s3_ff;
   logic [60:0] q_prod;
   logic [17:0] q_in;
   logic [32:0] back_prod;
   logic [14:0] fc_in;

   assign s3_ready = !s3_v_ff || out_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign s1_ready = !s1_v_ff || s2_ready;
   assign in_ready = s1_ready;

   assign q_prod = 61'(cc_s1_ff[31:2]) * 61'(FRAME_RECIP);
   assign q_in   = q_prod[FRAME_RECIP_SH +: 18];

   // The true remainder is below 2^15, so the low bits of the difference suffice.
   assign back_prod = 33'(q_s2_ff) * 33'(FRAME_CYCLES);
   assign fc_in     = cc_lo_s2_ff - back_prod[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_v_ff <= in_valid;
         if (s2_ready) s2_v_ff <= s1_v_ff;
         if (s3_ready) s3_v_ff <= s2_v_ff;
      end
      if (s1_ready) cc_s1_ff <= in_cycle_count;
      if (s2_ready) begin
         q_s2_ff     <= q_in;
         cc_lo_s2_ff <= cc_s1_ff[14:0];
      end
      if (s3_ready) fc_s3_ff <= fc_in;
   end

   assign out_valid = s3_v_ff;
   assign out_fc    = fc_s3_ff;

endmodule

`default_nettype wire

// File: rtl/lcdst_line_mode.sv
`default_nettype none

// Two stages: line number from the frame position, then the cycle within the
// line and the mode that it falls in.
module lcdst_line_mode
   import lcdst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [14:0] in_fc,
   output logic             out_valid,
   input  wire logic        out_ready,
   output pos_type          out_pos
);

   logic        s4_v_ff, s5_v_ff;
   logic        s4_ready, s5_ready;
   logic [28:0] line_prod;
   logic [7:0]  line_in;
   logic [7:0]  line_s4_ff;
   logic [6:0]  fc_lo_s4_ff;
   logic [14:0] line_base;
   logic [6:0]  lc;
   pos_type     pos_in;
   pos_type     pos_s5_ff;

   assign s5_ready = !s5_v_ff || out_ready;
   assign s4_ready = !s4_v_ff || s5_ready;
   assign in_ready = s4_ready;

   assign line_prod = 29'(in_fc[14:1]) * 29'(LINE_RECIP);
   assign line_in   = line_prod[LINE_RECIP_SH +: 8];

   assign line_base = 15'(line_s4_ff) * 15'(LINE_CYCLES);
   assign lc        = fc_lo_s4_ff - line_base[6:0];

   always_comb begin
      pos_in.line = line_s4_ff;
      priority if (line_s4_ff >= 8'(VISIBLE_LINES)) begin
         pos_in.mode = MODE_VBLANK;
      end else if (lc < 7'(OAM_CYCLES)) begin
         pos_in.mode = MODE_OAM;
      end else if (lc < 7'(OAM_CYCLES + XFER_CYCLES)) begin
         pos_in.mode = MODE_XFER;
      end else begin
         pos_in.mode = MODE_HBLANK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         if (s4_ready) s4_v_ff <= in_valid;
         if (s5_ready) s5_v_ff <= s4_v_ff;
      end
      if (s4_ready) begin
         line_s4_ff  <= line_in;
         fc_lo_s4_ff <= in_fc[6:0];
      end
      if (s5_ready) pos_s5_ff <= pos_in;
   end

   assign out_valid = s5_v_ff;
   assign out_pos   = pos_s5_ff;

endmodule

`default_nettype wire

// File: rtl/lcdst_stat_irq.sv
`default_nettype none

`include "lcd_mode_stat_timing_core_assert.svh"

// Configuration registers, previous-mode tracking and the result register.
module lcdst_irq_gen
   import lcdst_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire pos_type                in_pos,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output rsp_type                     out_rsp
);

   logic [3:0] irq_en_ff;
   logic [7:0] lyc_ff;
   mode_type   last_mode_ff;
   logic       rsp_v_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       load;

   assign in_ready = !rsp_v_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      rsp_in.mode        = in_pos.mode;
      rsp_in.line        = in_pos.line;
      rsp_in.vblank_irq  = 1'b0;
      rsp_in.stat_req    = 1'b0;
      rsp_in.frame_swap  = 1'b0;
      rsp_in.coincidence = (in_pos.line == lyc_ff);
      if (in_pos.mode != last_mode_ff) begin
         unique case (last_mode_ff)
            MODE_HBLANK: begin
               if (in_pos.mode == MODE_VBLANK) begin
                  rsp_in.vblank_irq = 1'b1;
                  rsp_in.stat_req   = irq_en_ff[EN_VBLANK];
               end else begin
                  rsp_in.stat_req   = irq_en_ff[EN_OAM];
               end
            end
            MODE_VBLANK: begin
               rsp_in.stat_req   = irq_en_ff[EN_OAM];
               rsp_in.frame_swap = 1'b1;
            end
            MODE_XFER: begin
               rsp_in.stat_req = irq_en_ff[EN_HBLANK];
            end
            MODE_OAM: begin
            end
         endcase
      end
      if (rsp_in.coincidence && irq_en_ff[EN_LYC]) begin
         rsp_in.stat_req = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_en_ff    <= '0;
         lyc_ff       <= '0;
         last_mode_ff <= MODE_OAM;
         rsp_v_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_IRQ_ENABLES:  irq_en_ff <= csr_wdata[3:0];
               CSR_LINE_COMPARE: lyc_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (in_ready) rsp_v_ff <= in_valid;
         if (load) last_mode_ff <= in_pos.mode;
      end
      if (load) rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_v_ff;
   assign out_rsp   = rsp_ff;

   `LCDST_ASSERT_IMPLIES(a_last_mode_tracks_rsp, clock, reset, rsp_v_ff,
      last_mode_ff == rsp_ff.mode)
   `LCDST_ASSERT_IMPLIES(a_vblank_irq_mode, clock, reset, rsp_v_ff && rsp_ff.vblank_irq,
      rsp_ff.mode == MODE_VBLANK)
   `LCDST_ASSERT_IMPLIES(a_swap_excl_vblank, clock, reset, rsp_v_ff,
      !(rsp_ff.vblank_irq && rsp_ff.frame_swap))
   `LCDST_ASSERT_IMPLIES(a_line_mode_agree, clock, reset, rsp_v_ff,
      (rsp_ff.line >= 8'(VISIBLE_LINES)) == (rsp_ff.mode == MODE_VBLANK))

endmodule

`default_nettype wire

// File: rtl/lcd_mode_stat_timing_core.sv
// LCD mode timing and STAT interrupt core. Each req beat carries the running CPU
// machine-cycle count; the core answers every beat with exactly one rsp beat that
// holds the LCD mode, the scanline, the line-compare flag and the vblank, STAT and
// frame-swap requests, in the order the beats came in. A new beat is taken every
// clock cycle while the receiver keeps up. A result passes through three stages for
// the frame position, two for line and mode, and one result register. Both divisions
// are reciprocal multiplies, each followed by a register. The previous mode lives in
// the result stage, so interrupt edges follow the order of delivered beats. Write
// irq_enables and line_compare only while no beat is in flight.
`default_nettype none

module lcd_mode_stat_timing_core
   import lcdst_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Configuration write port: index 0 irq_enables, index 1 line_compare.
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata,
   // Input beats.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [31:0]            req_tdata,   // [31:0] cycle_count
   // Result beats.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [15:0]                 rsp_tdata    // [1:0] mode, [9:2] line,
                                                    // [10] coincidence, [11] vblank_irq,
                                                    // [12] stat_req, [13] frame_swap,
                                                    // [15:14] zero
);

   // Frame position stage to line/mode stage.
   logic        fp_valid;
   logic        fp_ready;
   logic [14:0] fp_fc;

   // Line/mode stage to the interrupt and result stage.
   logic        lm_valid;
   logic        lm_ready;
   pos_type     lm_pos;

   rsp_type     rsp;

   // cycle_count modulo the frame length.
   lcdst_frame_pos u_frame_pos (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_cycle_count (req_tdata),
      .out_valid      (fp_valid),
      .out_ready      (fp_ready),
      .out_fc         (fp_fc)
   );

   // Scanline and mode from the frame position.
   lcdst_line_mode u_line_mode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fp_valid),
      .in_ready  (fp_ready),
      .in_fc     (fp_fc),
      .out_valid (lm_valid),
      .out_ready (lm_ready),
      .out_pos   (lm_pos)
   );

   // Mode-change and line-compare requests, then the result register.
   lcdst_irq_gen u_irq_gen (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (lm_valid),
      .in_ready  (lm_ready),
      .in_pos    (lm_pos),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   // The result struct is packed with mode in the lowest bits; pad to two bytes.
   assign rsp_tdata = {2'b00, rsp};

endmodule

`default_nettype wire

// File: dv/lcd_mode_stat_timing_core_test.sv
module lcd_mode_stat_timing_core_test
   import lcdst_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes that the core does not decode. A write to either must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   // Random beats per traffic phase, and the length of the long receiver hold-off.
   localparam int PHASE_BEATS   = 126;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 5000;
   localparam int REPORT_LIMIT  = 10;

   // The directed part is a list of rows. A row either sends one beat or writes one register.
   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [7:0]             wdata;
      logic [31:0]            cc;
      bit                     typed;    // golden holds a hand-written result
      rsp_type                golden;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata = '0;   // [31:0] cycle_count
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;        // [1:0] mode, [9:2] line, [10] coincidence,
                                             // [11] vblank_irq, [12] stat_req,
                                             // [13] frame_swap, [15:14] zero

   // Side information that travels with the beat on the request side. It is sampled
   // together with req_tdata, so the monitor knows which beats carry a typed result.
   bit      req_typed = 1'b0;
   rsp_type req_golden = '0;

   // Shadow of the core's registers and of its previous-mode state, owned by the monitor.
   logic [3:0] shadow_enables;
   logic [7:0] shadow_compare;
   mode_type   model_last_mode;

   // Results that the core still owes us, oldest first.
   rsp_type       pending_timing[$];
   stim_row_type  stim_rows[$];

   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   logic        hold_active = 1'b0;
   event        hold_go;

   int failures = 0;
   int beats_checked = 0;
   int csr_writes = 0;
   int stat_seen = 0;
   int vblank_seen = 0;
   int swap_seen = 0;
   int coin_seen = 0;

   rsp_type got_rsp;
   rsp_type want_rsp;

   lcd_mode_stat_timing_core DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Two nanosecond clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Works out the result for one cycle count and moves the shadow previous mode along.
   // The STAT sources depend on which mode is being left, not on the new one, except
   // that leaving hblank for vblank is the vblank edge rather than an OAM edge.
   function automatic rsp_type predict_timing(input logic [31:0] cc);
      int unsigned frame_pos;
      int unsigned line_no;
      int unsigned line_pos;
      mode_type    now_mode;
      rsp_type     r;
      frame_pos = cc % FRAME_CYCLES;
      line_no   = frame_pos / LINE_CYCLES;
      line_pos  = frame_pos % LINE_CYCLES;
      if (line_no >= VISIBLE_LINES) begin
         now_mode = MODE_VBLANK;
      end else if (line_pos < OAM_CYCLES) begin
         now_mode = MODE_OAM;
      end else if (line_pos < OAM_CYCLES + XFER_CYCLES) begin
         now_mode = MODE_XFER;
      end else begin
         now_mode = MODE_HBLANK;
      end
      r = '0;
      r.mode = now_mode;
      r.line = 8'(line_no);
      if (now_mode != model_last_mode) begin
         case (model_last_mode)
            MODE_HBLANK: begin
               if (now_mode == MODE_VBLANK) begin
                  r.vblank_irq = 1'b1;
                  if (shadow_enables[EN_VBLANK]) r.stat_req = 1'b1;
               end else if (shadow_enables[EN_OAM]) begin
                  r.stat_req = 1'b1;
               end
            end
            MODE_VBLANK: begin
               if (shadow_enables[EN_OAM]) r.stat_req = 1'b1;
               r.frame_swap = 1'b1;
            end
            MODE_XFER: begin
               if (shadow_enables[EN_HBLANK]) r.stat_req = 1'b1;
            end
            default: begin
            end
         endcase
      end
      model_last_mode = now_mode;
      // A compare value beyond the last line can never match.
      if (line_no == 32'(shadow_compare)) begin
         r.coincidence = 1'b1;
         if (shadow_enables[EN_LYC]) r.stat_req = 1'b1;
      end
      return r;
   endfunction

   function automatic rsp_type mk_rsp(input mode_type m, input logic [7:0] ln,
                                      input logic coin, input logic vb,
                                      input logic st, input logic sw);
      rsp_type r;
      r = '0;
      r.mode        = m;
      r.line        = ln;
      r.coincidence = coin;
      r.vblank_irq  = vb;
      r.stat_req    = st;
      r.frame_swap  = sw;
      return r;
   endfunction

   function automatic void add_beat(input logic [31:0] cc);
      stim_row_type row;
      row = '{kind: ROW_BEAT, index: '0, wdata: '0, cc: cc, typed: 1'b0, golden: '0};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_typed(input logic [31:0] cc, input rsp_type golden);
      stim_row_type row;
      row = '{kind: ROW_BEAT, index: '0, wdata: '0, cc: cc, typed: 1'b1, golden: golden};
      stim_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      stim_row_type row;
      row = '{kind: ROW_CSR, index: idx, wdata: val, cc: '0, typed: 1'b0, golden: '0};
      stim_rows.push_back(row);
   endfunction

   // Picks the start of a counting run at or just before a mode boundary: the start
   // of OAM search, of transfer, of hblank, or of vblank. Now and then the run starts
   // just below the top of the 32-bit count so that it may wrap through zero.
   function automatic logic [31:0] boundary_start();
      logic [31:0] base;
      int unsigned off;
      if ($urandom_range(9) == 0) return 32'hFFFF_FFFF - $urandom_range(30);
      base = $urandom;
      base = base - base % FRAME_CYCLES;
      case ($urandom_range(3))
         0:       off = 0;
         1:       off = OAM_CYCLES;
         2:       off = OAM_CYCLES + XFER_CYCLES;
         default: off = VISIBLE_LINES * LINE_CYCLES;
      endcase
      if (off != VISIBLE_LINES * LINE_CYCLES) off += $urandom_range(VISIBLE_LINES - 1) * LINE_CYCLES;
      return base + off - $urandom_range(3);
   endfunction

   function automatic void flag_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // Monitor. Everything is sampled at the rising edge, before the core's registers
   // and the testbench's nonblocking drives take effect, so it sees the values that the
   // edge itself acts on.
   always @(posedge clock) begin
      if (reset) begin
         shadow_enables  = '0;
         shadow_compare  = '0;
         model_last_mode = MODE_OAM;
         pending_timing.delete();
      end else begin
         if (csr_we) begin
            csr_writes++;
            case (csr_index)
               CSR_IRQ_ENABLES:  shadow_enables = csr_wdata[3:0];
               CSR_LINE_COMPARE: shadow_compare = csr_wdata;
               default: begin
               end
            endcase
         end
         // The predictor runs for every accepted beat so that its previous mode stays
         // in step; a typed row then replaces its answer with the hand-written one.
         if (req_tvalid && req_tready) begin
            want_rsp = predict_timing(req_tdata);
            if (req_typed) want_rsp = req_golden;
            pending_timing.push_back(want_rsp);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata[13:0];
            if (pending_timing.size() == 0) begin
               flag_failure($sformatf("result beat with nothing pending, tdata 0x%04h",
                                      rsp_tdata));
            end else begin
               want_rsp = pending_timing.pop_front();
               if (got_rsp.mode !== want_rsp.mode || got_rsp.line !== want_rsp.line
                   || got_rsp.coincidence !== want_rsp.coincidence
                   || got_rsp.vblank_irq !== want_rsp.vblank_irq
                   || got_rsp.stat_req !== want_rsp.stat_req
                   || got_rsp.frame_swap !== want_rsp.frame_swap
                   || rsp_tdata[15:14] !== 2'b00) begin
                  flag_failure($sformatf(
                     {"beat %0d: mode %0d/%0d line %0d/%0d coin %b/%b vblank %b/%b ",
                      "stat %b/%b swap %b/%b pad %b (expected/actual)"},
                     beats_checked, want_rsp.mode, got_rsp.mode, want_rsp.line, got_rsp.line,
                     want_rsp.coincidence, got_rsp.coincidence,
                     want_rsp.vblank_irq, got_rsp.vblank_irq,
                     want_rsp.stat_req, got_rsp.stat_req,
                     want_rsp.frame_swap, got_rsp.frame_swap, rsp_tdata[15:14]));
               end
               beats_checked++;
               stat_seen   += int'(got_rsp.stat_req);
               vblank_seen += int'(got_rsp.vblank_irq);
               swap_seen   += int'(got_rsp.frame_swap);
               coin_seen   += int'(got_rsp.coincidence);
            end
         end
      end
   end

   // Receiver. It stalls at the rate of the current phase, and not at all off-phase;
   // during a hold-off it refuses every result so that the pipeline backs up.
   always @(posedge clock) begin
      rsp_tready <= !hold_active && ($urandom_range(99) >= rx_stall_pct);
   end

   // The long hold-off is timed here, apart from the receiver's random stalls.
   initial begin
      forever begin
         @(hold_go);
         hold_active <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_active <= 1'b0;
      end
   end

   // Offers one beat after a random idle gap and returns at the edge that accepts it.
   // The valid stays high from one beat to the next when there is no gap.
   task automatic send_beat(input logic [31:0] cc, input bit typed, input rsp_type golden);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cc;
      req_typed  <= typed;
      req_golden <= golden;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Registers may only change while no beat is in flight. The first edge lets the
   // monitor log the beat that was just accepted; after that every owed result must
   // have come back, since each beat yields exactly one.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_timing.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [31:0] start;
      int          run_len;
      int          sent;
      int          waited;

      // Directed rows. Right after reset all enables are off and the compare value is
      // zero, so line 0 matches but raises no STAT request. The all-ones count lands
      // on line 129 in hblank, and leaving OAM search raises nothing.
      add_typed(32'd0, mk_rsp(MODE_OAM, 8'd0, 1'b1, 1'b0, 1'b0, 1'b0));
      add_typed(32'hFFFF_FFFF, mk_rsp(MODE_HBLANK, 8'd129, 1'b0, 1'b0, 1'b0, 1'b0));
      // All sources on; the upper bits of the enable write must be dropped.
      add_csr(CSR_IRQ_ENABLES, 8'hFF);
      add_csr(CSR_LINE_COMPARE, 8'(VISIBLE_LINES));
      // Every kind of mode change in turn, with the count jumping freely between them.
      add_beat(32'd16416);       // hblank to vblank, line 144 matches
      add_beat(32'd17555);       // last cycle of the frame, no change
      add_beat(32'd17556);       // next frame: vblank to OAM search, buffers swap
      add_beat(32'd20);          // OAM search to transfer raises nothing
      add_beat(32'd63);          // transfer to hblank
      add_beat(32'd114);         // hblank to OAM search
      add_beat(32'd133);         // still OAM search
      add_beat(32'd16421);       // OAM search straight to vblank
      add_beat(32'd62);          // vblank straight to transfer
      add_beat(32'd16500);       // transfer straight to vblank
      add_beat(32'd100);         // vblank straight to hblank
      add_beat(32'd40);          // hblank back to transfer
      add_beat(32'd200);         // transfer to hblank on line 1
      add_beat(32'd5);           // hblank to OAM search
      add_beat(32'hFFFF_FFFF);   // top of the count
      add_beat(32'd0);           // the count wraps through zero
      // A compare value past the last line never matches; nothing enabled.
      add_csr(CSR_LINE_COMPARE, 8'hFF);
      add_csr(CSR_IRQ_ENABLES, 8'h00);
      add_beat(32'd16416);
      add_beat(32'd17555);
      // Writes to undecoded indexes must change neither register.
      add_csr(CSR_SPARE_A, 8'hFF);
      add_csr(CSR_SPARE_B, 8'h99);
      add_beat(32'd114);
      // Only the line-compare source, on the very last line.
      add_csr(CSR_IRQ_ENABLES, 8'h08);
      add_csr(CSR_LINE_COMPARE, 8'd153);
      add_beat(32'd17555);
      add_beat(32'd17442);

      // Reset is held from time zero and released once.
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            write_csr(stim_rows[i].index, stim_rows[i].wdata);
         end else begin
            send_beat(stim_rows[i].cc, stim_rows[i].typed, stim_rows[i].golden);
         end
      end

      // Random traffic in five phases, each with its own register setting and idling.
      // Most beats come in counting runs across a mode boundary, as the CPU would
      // issue them; the rest are single beats at arbitrary counts.
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_IRQ_ENABLES, 8'h0F);
               write_csr(CSR_LINE_COMPARE, 8'd0);
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               write_csr(CSR_IRQ_ENABLES, 8'hF0);
               write_csr(CSR_LINE_COMPARE, 8'd153);
               tx_idle_pct  = 59;
               rx_stall_pct = 0;
            end
            2: begin
               write_csr(CSR_IRQ_ENABLES, 8'($urandom));
               write_csr(CSR_LINE_COMPARE, 8'hFF);
               tx_idle_pct  = 0;
               rx_stall_pct = 59;
            end
            3: begin
               write_csr(CSR_IRQ_ENABLES, 8'($urandom));
               write_csr(CSR_LINE_COMPARE, 8'($urandom_range(153)));
               write_csr(CSR_SPARE_A, 8'($urandom));
               tx_idle_pct  = 27;
               rx_stall_pct = 27;
            end
            default: begin
               // The receiver holds off for a long stretch while beats keep coming.
               write_csr(CSR_IRQ_ENABLES, 8'h0F);
               write_csr(CSR_LINE_COMPARE, 8'($urandom_range(153)));
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
               -> hold_go;
            end
         endcase
         sent = 0;
         while (sent < PHASE_BEATS) begin
            if ($urandom_range(9) < 7) begin
               start   = boundary_start();
               run_len = $urandom_range(40, 4);
               for (int k = 0; k < run_len && sent < PHASE_BEATS; k++) begin
                  send_beat(start + 32'(k), 1'b0, '0);
                  sent++;
               end
            end else begin
               send_beat($urandom, 1'b0, '0);
               sent++;
            end
         end
      end

      // Let the last results come home, then give stray beats a chance to show up.
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_timing.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
      if (pending_timing.size() != 0) begin
         flag_failure($sformatf("%0d results never arrived", pending_timing.size()));
         failures += pending_timing.size() - 1;
      end

      $display("Covered %0d beats and %0d register writes in five traffic phases.",
               beats_checked, csr_writes);
      $display("Seen: %0d STAT, %0d vblank, %0d frame-swap and %0d line-match results.",
               stat_seen, vblank_seen, swap_seen, coin_seen);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures in total.", failures);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #400000;
      $display("Timed out with %0d results still pending.", pending_timing.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/lcdst_pkg.sv
rtl/lcdst_frame_pos.sv
rtl/lcdst_line_mode.sv
rtl/lcdst_stat_irq.sv
rtl/lcd_mode_stat_timing_core.sv
dv/lcd_mode_stat_timing_core_test.sv
